// File: rtl/core/multi_key_debounce_longpress_defines.svh
// Assertion macros used by the multi-key debouncer top level.
`ifndef MULTI_KEY_DEBOUNCE_LONGPRESS_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_LONGPRESS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define MKDL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define MKDL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mkdl_pkg.sv
// Package with the constants and types of the multi-key debouncer.
`timescale 1ns / 1ps
package mkdl_pkg;

    localparam int NUM_KEYS    = 9;
    localparam int TIME_BITS   = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int KIND_W      = 2;
    localparam int KEY_FIELD_W = 4;
    localparam int KEY_IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(NUM_KEYS - 1);

    localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] EV_UP   = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [CFG_W-1:0] LONGPRESS_RST = 16'd1000;

    typedef struct packed {
        logic                 running;
        logic [TIME_BITS-1:0] deb_start;
        logic [TIME_BITS-1:0] press_start;
        logic                 long_done;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              vld;
        logic [KIND_W-1:0] kind;
    } t_key_res;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [KEY_FIELD_W-1:0] key_index;
        logic [NUM_KEYS-1:0]    pressed_mask;
        logic [KEY_FIELD_W-1:0] recent_key;
        logic                   recent_key_down;
    } t_event;

endpackage

// File: rtl/core/mkdl_if.sv
// Valid/ready channel interfaces for key ticks and key events.
`timescale 1ns / 1ps
interface mkdl_in_if;
    logic                             valid;
    logic                             ready;
    logic [mkdl_pkg::NUM_KEYS-1:0]    raw_levels;
    logic [mkdl_pkg::TIME_BITS-1:0]   now_ms;

    modport source (output valid, output raw_levels, output now_ms, input ready);
    modport sink (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface mkdl_out_if;
    logic                               valid;
    logic                               ready;
    logic [mkdl_pkg::KIND_W-1:0]        event_kind;
    logic [mkdl_pkg::KEY_FIELD_W-1:0]   key_index;
    logic [mkdl_pkg::NUM_KEYS-1:0]      pressed_mask;
    logic [mkdl_pkg::KEY_FIELD_W-1:0]   recent_key;
    logic                               recent_key_down;
    logic                               last;

    modport source (output valid, output event_kind, output key_index, output pressed_mask,
                    output recent_key, output recent_key_down, output last, input ready);
    modport sink (input valid, input event_kind, input key_index, input pressed_mask,
                  input recent_key, input recent_key_down, input last, output ready);
endinterface

// File: rtl/core/mkdl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module mkdl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mkdl_key_eval.sv
// Per-key debounce and long-press decision on one state entry.
`timescale 1ns / 1ps
module mkdl_key_eval (
    input  logic                             i_low,
    input  logic                             i_was,
    input  mkdl_pkg::t_entry                 i_ent,
    input  logic [mkdl_pkg::TIME_BITS-1:0]   i_now,
    input  logic [mkdl_pkg::CFG_W-1:0]       i_debounce_ms,
    input  logic [mkdl_pkg::CFG_W-1:0]       i_longpress_ms,
    output mkdl_pkg::t_entry                 o_ent,
    output mkdl_pkg::t_key_res               o_res
);

    logic [mkdl_pkg::TIME_BITS-1:0] deb_start;
    logic [mkdl_pkg::TIME_BITS-1:0] deb_age;
    logic [mkdl_pkg::TIME_BITS-1:0] press_age;

    assign deb_start = i_ent.running ? i_ent.deb_start : i_now;
    assign deb_age   = i_now - deb_start;
    assign press_age = i_now - i_ent.press_start;

    always_comb begin
        o_ent      = i_ent;
        o_res.vld  = 1'b0;
        o_res.kind = mkdl_pkg::EV_DOWN;
        if (i_low && !i_was) begin
            o_ent.running   = 1'b1;
            o_ent.deb_start = deb_start;
            if (deb_age >= mkdl_pkg::TIME_BITS'(i_debounce_ms)) begin
                o_ent.press_start = i_now;
                o_ent.long_done   = 1'b0;
                o_res.vld         = 1'b1;
                o_res.kind        = mkdl_pkg::EV_DOWN;
            end
        end else if (!i_low) begin
            o_ent.running   = 1'b0;
            o_ent.deb_start = '0;
            if (i_was) begin
                o_res.vld  = 1'b1;
                o_res.kind = mkdl_pkg::EV_UP;
            end
        end else if (!i_ent.long_done) begin
            if (press_age >= mkdl_pkg::TIME_BITS'(i_longpress_ms)) begin
                o_ent.long_done = 1'b1;
                o_res.vld       = 1'b1;
                o_res.kind      = mkdl_pkg::EV_LONG;
            end
        end
    end

endmodule

// File: rtl/core/multi_key_debounce_longpress.sv
// Top level of the multi-key debouncer with long-press detection.
//
// Usage: each word on i_in is one poll tick with the active-low key levels and
// a wrapping millisecond timestamp. For every key, in ascending order, the
// block may emit one event word on o_out: key down, key up or long press, with
// the debounced pressed mask and the most recent key after that event. The
// last event word of a tick has last set; a tick without events emits nothing.
// Per-key timing state lives in a small RAM that a sequencer walks one key per
// cycle unless a new event must wait for the output register, reading the next
// key while it writes back the current one. Each event waits in a pending
// register until the next event of the same tick or the end of the key walk,
// and then moves on to the output register. One tick is in work at a time;
// i_in.ready is high only between ticks. When the receiver stalls, the output
// register and one pending event hold, and the key walk pauses at a key with a
// new event until the output register frees. Reset clears all key state and
// the pressed mask through per-entry valid bits, and sets debounce to 20 ms
// and long press to 1000 ms. Configuration writes take effect at once; they
// are to be made between ticks by the user, as the block does not enforce it.
`timescale 1ns / 1ps
`include "multi_key_debounce_longpress_defines.svh"
module multi_key_debounce_longpress (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mkdl_in_if.sink                           i_in,
    mkdl_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [mkdl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mkdl_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EX   = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam int KW = mkdl_pkg::KEY_IDX_W;

    logic [1:0]                     r_state, n_state;
    logic [KW-1:0]                  r_key, n_key;
    logic [mkdl_pkg::NUM_KEYS-1:0]  r_levels, n_levels;
    logic [mkdl_pkg::TIME_BITS-1:0] r_now, n_now;
    logic [mkdl_pkg::NUM_KEYS-1:0]  r_pressed, n_pressed;
    logic [mkdl_pkg::KEY_FIELD_W-1:0] r_recent_key, n_recent_key;
    logic                           r_recent_down, n_recent_down;
    logic [mkdl_pkg::NUM_KEYS-1:0]  r_ent_vld, n_ent_vld;
    logic                           r_rd_vld, n_rd_vld;
    logic                           r_pend_vld, n_pend_vld;
    mkdl_pkg::t_event               r_pend, n_pend;
    logic                           r_out_vld, n_out_vld;
    mkdl_pkg::t_event               r_out, n_out;
    logic                           r_out_last, n_out_last;
    logic [mkdl_pkg::CFG_W-1:0]     r_deb, n_deb;
    logic [mkdl_pkg::CFG_W-1:0]     r_lp, n_lp;

    logic                           rd_en;
    logic [KW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [mkdl_pkg::ENTRY_W-1:0]   ram_rdata;
    mkdl_pkg::t_entry               cur_ent;
    mkdl_pkg::t_entry               new_ent;
    mkdl_pkg::t_key_res             key_res;
    logic                           out_free;

    assign cur_ent  = r_rd_vld ? mkdl_pkg::t_entry'(ram_rdata) : '0;
    assign out_free = !r_out_vld || o_out.ready;

    mkdl_ram #(
        .WIDTH  (mkdl_pkg::ENTRY_W),
        .DEPTH  (mkdl_pkg::NUM_KEYS),
        .ADDR_W (KW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_key),
        .i_wdata (new_ent),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    mkdl_key_eval u_eval (
        .i_low          (!r_levels[r_key]),
        .i_was          (r_pressed[r_key]),
        .i_ent          (cur_ent),
        .i_now          (r_now),
        .i_debounce_ms  (r_deb),
        .i_longpress_ms (r_lp),
        .o_ent          (new_ent),
        .o_res          (key_res)
    );

    always_comb begin
        n_state       = r_state;
        n_key         = r_key;
        n_levels      = r_levels;
        n_now         = r_now;
        n_pressed     = r_pressed;
        n_recent_key  = r_recent_key;
        n_recent_down = r_recent_down;
        n_ent_vld     = r_ent_vld;
        n_rd_vld      = r_rd_vld;
        n_pend_vld    = r_pend_vld;
        n_pend        = r_pend;
        n_out_vld     = r_out_vld && !o_out.ready;
        n_out         = r_out;
        n_out_last    = r_out_last;
        n_deb         = r_deb;
        n_lp          = r_lp;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mkdl_pkg::REG_DEBOUNCE:  n_deb = i_cfg_data;
                mkdl_pkg::REG_LONGPRESS: n_lp  = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_levels = i_in.raw_levels;
                    n_now    = i_in.now_ms;
                    n_key    = '0;
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    n_state  = S_EX;
                end
            end
            S_EX: begin
                if (!(key_res.vld && r_pend_vld && !out_free)) begin
                    wr_en            = 1'b1;
                    n_ent_vld[r_key] = 1'b1;
                    if (key_res.vld) begin
                        if (key_res.kind == mkdl_pkg::EV_DOWN) begin
                            n_pressed[r_key] = 1'b1;
                            n_recent_key     = mkdl_pkg::KEY_FIELD_W'(r_key + 1'b1);
                            n_recent_down    = 1'b1;
                        end else if (key_res.kind == mkdl_pkg::EV_UP) begin
                            n_pressed[r_key] = 1'b0;
                            n_recent_down    = 1'b0;
                        end
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out      = r_pend;
                            n_out_last = 1'b0;
                        end
                        n_pend_vld             = 1'b1;
                        n_pend.kind            = key_res.kind;
                        n_pend.key_index       = mkdl_pkg::KEY_FIELD_W'(r_key);
                        n_pend.pressed_mask    = n_pressed;
                        n_pend.recent_key      = n_recent_key;
                        n_pend.recent_key_down = n_recent_down;
                    end
                    if (r_key == mkdl_pkg::KEY_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_key   = r_key + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_key + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (rd_en) begin
            n_rd_vld = r_ent_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_key         <= '0;
            r_pressed     <= '0;
            r_recent_key  <= '0;
            r_recent_down <= 1'b0;
            r_ent_vld     <= '0;
            r_rd_vld      <= 1'b0;
            r_pend_vld    <= 1'b0;
            r_out_vld     <= 1'b0;
            r_deb         <= mkdl_pkg::DEBOUNCE_RST;
            r_lp          <= mkdl_pkg::LONGPRESS_RST;
        end else begin
            r_state       <= n_state;
            r_key         <= n_key;
            r_pressed     <= n_pressed;
            r_recent_key  <= n_recent_key;
            r_recent_down <= n_recent_down;
            r_ent_vld     <= n_ent_vld;
            r_rd_vld      <= n_rd_vld;
            r_pend_vld    <= n_pend_vld;
            r_out_vld     <= n_out_vld;
            r_deb         <= n_deb;
            r_lp          <= n_lp;
        end
        r_levels   <= n_levels;
        r_now      <= n_now;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_vld;
    assign o_out.event_kind      = r_out.kind;
    assign o_out.key_index       = r_out.key_index;
    assign o_out.pressed_mask    = r_out.pressed_mask;
    assign o_out.recent_key      = r_out.recent_key;
    assign o_out.recent_key_down = r_out.recent_key_down;
    assign o_out.last            = r_out_last;

    `MKDL_ASSERT_IMP(a_key_range, r_state == S_EX, r_key <= mkdl_pkg::KEY_LAST, "key counter out of range")
    `MKDL_ASSERT_NXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready after accept")
    `MKDL_ASSERT_IMP(a_pend_not_stranded, r_pend_vld, r_state != S_IDLE, "pending event left in idle")
    `MKDL_ASSERT_IMP(a_kind_legal, o_out.valid, o_out.event_kind == mkdl_pkg::EV_DOWN || o_out.event_kind == mkdl_pkg::EV_UP || o_out.event_kind == mkdl_pkg::EV_LONG, "illegal event kind")

endmodule

// File: test/mkdl_event_checker.sv
// Checker that predicts the debouncer event words and compares them with the block output.
`timescale 1ns / 1ps
module mkdl_event_checker
    import mkdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mkdl_in_if                   i_tick_mon,
    mkdl_out_if                  i_event_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_expected_left
);

    typedef struct packed {
        t_event ev;
        logic   last;
    } t_event_word;

    logic [CFG_W-1:0]       debounce_cfg;
    logic [CFG_W-1:0]       longpress_cfg;
    logic [NUM_KEYS-1:0]    pressed;
    logic [TIME_BITS-1:0]   deb_start [NUM_KEYS];
    logic                   deb_running [NUM_KEYS];
    logic [TIME_BITS-1:0]   press_start [NUM_KEYS];
    logic                   long_fired [NUM_KEYS];
    logic [KEY_FIELD_W-1:0] recent_key;
    logic                   recent_down;
    t_event_word            expected_words [$];
    t_event_word            seen;
    t_event_word            want;
    int                     fail_count = 0;

    initial o_expected_left = 0;
    assign o_fail_count = fail_count;

    function automatic void add_event(input logic [KIND_W-1:0] kind, input int key);
        t_event_word w;
        w.ev.kind            = kind;
        w.ev.key_index       = KEY_FIELD_W'(key);
        w.ev.pressed_mask    = pressed;
        w.ev.recent_key      = recent_key;
        w.ev.recent_key_down = recent_down;
        w.last               = 1'b0;
        expected_words.push_back(w);
    endfunction

    task automatic debounce_tick(input logic [NUM_KEYS-1:0] levels,
                                 input logic [TIME_BITS-1:0] now);
        int                   prior_count;
        logic [TIME_BITS-1:0] elapsed;
        prior_count = expected_words.size();
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!levels[k] && !pressed[k]) begin
                if (!deb_running[k]) begin
                    deb_running[k] = 1'b1;
                    deb_start[k]   = now;
                end
                elapsed = now - deb_start[k];
                if (elapsed >= TIME_BITS'(debounce_cfg)) begin
                    pressed[k]     = 1'b1;
                    press_start[k] = now;
                    long_fired[k]  = 1'b0;
                    recent_key     = KEY_FIELD_W'(k + 1);
                    recent_down    = 1'b1;
                    add_event(EV_DOWN, k);
                end
            end else if (levels[k]) begin
                deb_running[k] = 1'b0;
                deb_start[k]   = '0;
                if (pressed[k]) begin
                    pressed[k]  = 1'b0;
                    recent_down = 1'b0;
                    add_event(EV_UP, k);
                end
            end else if (!long_fired[k]) begin
                elapsed = now - press_start[k];
                if (elapsed >= TIME_BITS'(longpress_cfg)) begin
                    long_fired[k] = 1'b1;
                    add_event(EV_LONG, k);
                end
            end
        end
        if (expected_words.size() > prior_count) begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce_cfg  = DEBOUNCE_RST;
            longpress_cfg = LONGPRESS_RST;
            pressed       = '0;
            recent_key    = '0;
            recent_down   = 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                deb_start[k]   = '0;
                deb_running[k] = 1'b0;
                press_start[k] = '0;
                long_fired[k]  = 1'b0;
            end
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DEBOUNCE) begin
                    debounce_cfg = i_cfg_data;
                end else if (i_cfg_idx == REG_LONGPRESS) begin
                    longpress_cfg = i_cfg_data;
                end
            end
            if (i_tick_mon.valid && i_tick_mon.ready) begin
                debounce_tick(i_tick_mon.raw_levels, i_tick_mon.now_ms);
            end
            if (i_event_mon.valid && i_event_mon.ready) begin
                seen.ev.kind            = i_event_mon.event_kind;
                seen.ev.key_index       = i_event_mon.key_index;
                seen.ev.pressed_mask    = i_event_mon.pressed_mask;
                seen.ev.recent_key      = i_event_mon.recent_key;
                seen.ev.recent_key_down = i_event_mon.recent_key_down;
                seen.last               = i_event_mon.last;
                if (expected_words.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected event word: kind %0d key %0d mask %03h",
                                 $time, seen.ev.kind, seen.ev.key_index, seen.ev.pressed_mask);
                    end
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (seen !== want) begin
                        if (fail_count < 10) begin
                            $display({"%0t: event word mismatch: expected kind %0d key %0d ",
                                      "mask %03h recent %0d down %0b last %0b"},
                                     $time, want.ev.kind, want.ev.key_index,
                                     want.ev.pressed_mask, want.ev.recent_key,
                                     want.ev.recent_key_down, want.last);
                            $display({"%0t:                    actual kind %0d key %0d ",
                                      "mask %03h recent %0d down %0b last %0b"},
                                     $time, seen.ev.kind, seen.ev.key_index,
                                     seen.ev.pressed_mask, seen.ev.recent_key,
                                     seen.ev.recent_key_down, seen.last);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_expected_left <= expected_words.size();
    end

endmodule

// File: test/testbench.sv
// Top of the debouncer testbench: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import mkdl_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                   i_clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_W-1:0]       cfg_data;
    logic                   sink_ready = 1'b0;
    logic                   no_idle = 1'b0;
    int                     stall_left = 0;
    int                     stall_len;
    int                     quiet_cycles = 0;
    int                     fail_count;
    int                     expected_left;
    int                     debounce_set;
    int                     longpress_set;
    logic [TIME_BITS-1:0]   now_t;

    mkdl_in_if  tick_ch ();
    mkdl_out_if event_ch ();

    assign event_ch.ready = sink_ready;

    multi_key_debounce_longpress DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in       (tick_ch),
        .o_out      (event_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mkdl_event_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_tick_mon      (tick_ch),
        .i_event_mon     (event_ch),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TIME_BITS-1:0] time_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return $urandom_range(0, debounce_set + 2);
        end else if (r < 80) begin
            return $urandom_range(0, longpress_set / 4 + 2);
        end else if (r < 95) begin
            return $urandom_range(0, longpress_set + debounce_set + 4);
        end
        return $urandom;
    endfunction

    // The receiver stalls after some accepted words and now and then while idle.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= (stall_left == 1);
        end else if ((event_ch.valid && event_ch.ready) || $urandom_range(0, 19) == 0) begin
            stall_len = pick_gap();
            stall_left <= stall_len;
            sink_ready <= (stall_len == 0);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (event_ch.valid && event_ch.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_tick(input logic [NUM_KEYS-1:0] levels, input logic [TIME_BITS-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.raw_levels <= levels;
        tick_ch.now_ms     <= t;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lp);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_DEBOUNCE;
        cfg_data <= deb;
        @(posedge i_clk);
        cfg_idx  <= REG_LONGPRESS;
        cfg_data <= lp;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        debounce_set  = int'(deb);
        longpress_set = int'(lp);
    endtask

    // Keys mostly hold their level for several ticks; some ticks bounce every pin at random.
    task automatic random_ticks(input int count);
        logic [NUM_KEYS-1:0] pins;
        pins  = '1;
        now_t = $urandom;
        repeat (count) begin
            if ($urandom_range(0, 19) == 0) begin
                no_idle <= !no_idle;
            end
            if ($urandom_range(0, 9) == 0) begin
                pins = NUM_KEYS'($urandom);
            end else begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        pins[k] = !pins[k];
                    end
                end
            end
            now_t = now_t + time_step();
            send_tick(pins, now_t);
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_DEBOUNCE;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.raw_levels = '1;
        tick_ch.now_ms     = '0;
        debounce_set       = int'(DEBOUNCE_RST);
        longpress_set      = int'(LONGPRESS_RST);
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        send_tick(9'h1FF, 32'd0);
        send_tick(9'h000, 32'd100);
        send_tick(9'h000, 32'd119);
        send_tick(9'h000, 32'd120);
        send_tick(9'h000, 32'd1119);
        send_tick(9'h000, 32'd1120);
        send_tick(9'h008, 32'd1200);
        send_tick(9'h1FF, 32'd1300);
        send_tick(9'h1FE, 32'hFFFF_FFF8);
        send_tick(9'h1FE, 32'hFFFF_FFFF);
        send_tick(9'h1FE, 32'h0000_000C);
        send_tick(9'h1FE, 32'h0000_03F4);
        send_tick(9'h1FF, 32'h0000_0400);
        send_tick(9'h0FF, 32'd2000);
        send_tick(9'h1FF, 32'd2010);
        send_tick(9'h0FF, 32'd2015);
        send_tick(9'h0FF, 32'd2034);
        send_tick(9'h0FF, 32'd2035);
        send_tick(9'h1FF, 32'd2100);
        random_ticks(70);

        wait_idle();
        write_config('0, '0);
        now_t = $urandom;
        send_tick(9'h1FF, now_t);
        send_tick(9'h1DF, now_t);
        send_tick(9'h1DF, now_t);
        send_tick(9'h1FF, now_t + 1);
        random_ticks(65);

        wait_idle();
        write_config('1, '1);
        random_ticks(65);

        wait_idle();
        write_config(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 300)));
        random_ticks(47);

        wait_idle();
        if (fail_count == 0 && expected_left == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
